/* rtl/fractional_lif_neuron_step_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the fractional LIF neuron
// Concurrent checks sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_LIF_NEURON_STEP_MACROS_SVH
`define FRACTIONAL_LIF_NEURON_STEP_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define FLNS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define FLNS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* rtl/flns_pkg.sv */
// ----------------------------------------------------------------------------
// flns_pkg
// Shared types and constants of the fractional LIF neuron.
// ----------------------------------------------------------------------------
package flns_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COEFF_W   = 17;
  localparam int unsigned SINCE_W   = 17;
  localparam int unsigned GM_W      = 51;

  localparam logic [SINCE_W-1:0] SINCE_MAX = 17'h1_FFFF;

  localparam logic [31:0] RST_LEAK_GAIN  = 32'd655;
  localparam logic [31:0] RST_INPUT_GAIN = 32'd65536;
  localparam logic [31:0] RST_REST       = 32'd0;
  localparam logic [31:0] RST_THRESHOLD  = 32'd65536;
  localparam logic [31:0] RST_RESET_POT  = 32'd0;
  localparam logic [15:0] RST_REFRACTORY = 16'd2;
  localparam logic [10:0] RST_HIST_LEN   = 11'd1024;

  typedef enum logic [0:0] {
    CMD_STEP  = 1'b0,
    CMD_COEFF = 1'b1
  } flns_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEAK_GAIN  = 3'd0,
    REG_INPUT_GAIN = 3'd1,
    REG_REST       = 3'd2,
    REG_THRESHOLD  = 3'd3,
    REG_RESET_POT  = 3'd4,
    REG_REFRACTORY = 3'd5,
    REG_HIST_LEN   = 3'd6
  } flns_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_ROT,
    ST_DRAIN,
    ST_SUM,
    ST_OUT
  } flns_state_e;

  typedef enum logic [2:0] {
    GM_IDLE,
    GM_LO,
    GM_HI,
    GM_SUM,
    GM_RND,
    GM_SIGN
  } flns_gm_phase_e;

  // Valid and keep flags of one history tap presented to the multiply-accumulate.
  typedef struct packed {
    logic valid;
    logic keep;
  } flns_tap_t;

endpackage

/* rtl/fractional_lif_neuron_step.sv */
// ----------------------------------------------------------------------------
// fractional_lif_neuron_step
// Fractional-order leaky integrate-and-fire neuron, Caputo L1 memory.
// ----------------------------------------------------------------------------
// A step transaction (tuser = 0) carries a Q16.16 drive current and returns
// one result: the spike flag and the membrane potential after the step. A
// coefficient transaction (tuser = 1) loads one Q1.16 tap weight into the
// coefficient RAM and returns nothing; every tap that
// history_length puts in use must be loaded before a step reads it. The
// deviation history is a ring of MEMORY_DEPTH cells. An active step pushes
// V - reset_potential into cell 0, then rotates the whole ring once around
// so that every tap passes the single multiply-accumulate, which leaves the
// ring where it started. An active step thus holds off the next acceptance
// until that walk through the one multiplier is done; a refractory step goes
// straight to the output, and a coefficient write leaves the block idle.
// Both gain products run on their own sequential multipliers during the walk.
// A new transaction is accepted while the previous result still waits on
// the output register; a step stalls only when it finishes and that register
// is still full. Registers are written through the config channel, which is
// always ready; write it only while no step is in progress.
// ----------------------------------------------------------------------------
`include "fractional_lif_neuron_step_macros.svh"

module fractional_lif_neuron_step #(
  parameter int unsigned MEMORY_DEPTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: [31:0] drive_current, [41:32] coeff_index, [58:42] coeff_value,
  //        [63:59] zero
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [63:0]                    s_axis_tdata_i,
  // tuser: [0] command
  input  logic [0:0]                     s_axis_tuser_i,
  // tdata: [0] spike, [32:1] membrane, [39:33] zero
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [39:0]                    m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [flns_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import flns_pkg::*;

  localparam int unsigned IDX_W = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1;
  localparam int unsigned MEM_W = IDX_W + 35;
  localparam int unsigned SUM_W = ((MEM_W > GM_W) ? MEM_W : GM_W) + 2;
  localparam logic [IDX_W-1:0] LAST_TAP = IDX_W'(MEMORY_DEPTH - 1);

  // --------------------------------------------------------------------------
  // Input field unpacking
  // --------------------------------------------------------------------------
  logic signed [31:0]  in_drive;
  logic [9:0]          in_cidx;
  logic [COEFF_W-1:0]  in_cval;
  logic [31:0]         in_cidx_ext;

  assign in_drive    = s_axis_tdata_i[31:0];
  assign in_cidx     = s_axis_tdata_i[41:32];
  assign in_cval     = s_axis_tdata_i[58:42];
  assign in_cidx_ext = 32'(in_cidx);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0]        leak_gain_q;
  logic [31:0]        input_gain_q;
  logic signed [31:0] rest_q;
  logic signed [31:0] thr_q;
  logic signed [31:0] reset_q;
  logic [15:0]        refr_steps_q;
  logic [10:0]        hist_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leak_gain_q  <= RST_LEAK_GAIN;
      input_gain_q <= RST_INPUT_GAIN;
      rest_q       <= RST_REST;
      thr_q        <= RST_THRESHOLD;
      reset_q      <= RST_RESET_POT;
      refr_steps_q <= RST_REFRACTORY;
      hist_len_q   <= RST_HIST_LEN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (flns_reg_e'(cfg_index_i))
        REG_LEAK_GAIN:  leak_gain_q  <= cfg_data_i;
        REG_INPUT_GAIN: input_gain_q <= cfg_data_i;
        REG_REST:       rest_q       <= cfg_data_i;
        REG_THRESHOLD:  thr_q        <= cfg_data_i;
        REG_RESET_POT:  reset_q      <= cfg_data_i;
        REG_REFRACTORY: refr_steps_q <= cfg_data_i[15:0];
        REG_HIST_LEN:   hist_len_q   <= cfg_data_i[10:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Control state and datapath registers
  // --------------------------------------------------------------------------
  flns_state_e state_q, state_d;

  logic signed [31:0]      v_q;
  logic [SINCE_W-1:0]      since_q;
  logic signed [31:0]      drive_q;
  logic signed [32:0]      dev_q;       // V - rest for the leak product
  logic [31:0]             hist_in_q;   // saturated V - reset for the ring
  logic                    refr_q;
  logic [IDX_W-1:0]        tap_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    out_valid_q;
  logic                    out_spike_q;
  logic signed [31:0]      out_memb_q;

  logic                    in_fire;
  logic                    step_fire;
  logic                    coeff_we;
  logic                    is_refr;
  logic                    out_free;
  logic                    out_load;
  logic                    chain_en;
  logic                    chain_load;
  logic                    gm_start;
  logic                    mac_clear;
  flns_tap_t               tap;

  logic signed [32:0]      v_rest;
  logic signed [32:0]      v_reset;
  logic [31:0]             hist_sat;

  logic                    mac_busy;
  logic signed [MEM_W-1:0] mem_term;
  logic [COEFF_W-1:0]      coeff_rd;
  logic                    gm_in_done;
  logic                    gm_leak_done;
  logic                    gm_done;
  logic signed [GM_W-1:0]  gm_in_res;
  logic signed [GM_W-1:0]  gm_leak_res;

  logic signed [SUM_W-1:0] sum_d;
  logic                    ovf_hi;
  logic                    ovf_lo;
  logic signed [31:0]      v_sat;
  logic                    fire;
  logic signed [31:0]      v_next;
  logic [SINCE_W-1:0]      since_next;

  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign step_fire = in_fire && (flns_cmd_e'(s_axis_tuser_i) == CMD_STEP);
  // slots past the RAM depth are dropped
  assign coeff_we  = in_fire && (flns_cmd_e'(s_axis_tuser_i) == CMD_COEFF) &&
                     (in_cidx_ext < MEMORY_DEPTH);
  assign is_refr   = (since_q <= {1'b0, refr_steps_q});
  assign out_free  = !out_valid_q || m_axis_tready_i;

  // Deviations seen at acceptance
  assign v_rest   = {v_q[31], v_q} - {rest_q[31], rest_q};
  assign v_reset  = {v_q[31], v_q} - {reset_q[31], reset_q};
  assign hist_sat = (v_reset[32] != v_reset[31]) ?
                    (v_reset[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : v_reset[31:0];

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (step_fire) state_d = is_refr ? ST_OUT : ST_SHIFT;
      ST_SHIFT: state_d = ST_ROT;
      ST_ROT:   if (tap_q == '0) state_d = ST_DRAIN;
      ST_DRAIN: if (!mac_busy && gm_done) state_d = ST_SUM;
      ST_SUM:   state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    chain_load      = (state_q == ST_SHIFT);
    chain_en        = (state_q == ST_SHIFT) || (state_q == ST_ROT);
    gm_start        = (state_q == ST_SHIFT);
    mac_clear       = (state_q == ST_SHIFT);
    tap.valid       = (state_q == ST_ROT);
    // the tap passing the end of the ring counts only if it is in use
    tap.keep        = (32'(hist_len_q) > 32'(tap_q));
    out_load        = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      v_q         <= RST_RESET_POT;
      since_q     <= SINCE_MAX;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        v_q         <= v_next;
        since_q     <= since_next;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      drive_q   <= in_drive;
      dev_q     <= v_rest;
      hist_in_q <= hist_sat;
      refr_q    <= is_refr;
    end
    // walk the taps from the far end of the ring down to tap zero
    if (state_q == ST_SHIFT) begin
      tap_q <= LAST_TAP;
    end else if (state_q == ST_ROT) begin
      tap_q <= tap_q - IDX_W'(1);
    end
    if (state_q == ST_SUM) begin
      sum_q <= sum_d;
    end
    if (out_load) begin
      out_spike_q <= fire;
      out_memb_q  <= v_next;
    end
  end

  // --------------------------------------------------------------------------
  // History ring: cell 0 takes the new deviation on a push, else the last cell
  // --------------------------------------------------------------------------
  logic [31:0] cell_w [MEMORY_DEPTH];
  logic [31:0] link_w [MEMORY_DEPTH];

  for (genvar k = 0; k < MEMORY_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign link_w[k] = chain_load ? hist_in_q : cell_w[MEMORY_DEPTH-1];
    end else begin : g_body
      assign link_w[k] = cell_w[k-1];
    end
    flns_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (chain_en),
      .data_i (link_w[k]),
      .data_o (cell_w[k])
    );
  end

  // --------------------------------------------------------------------------
  // Coefficient RAM: written by coefficient transactions, read during the walk
  // --------------------------------------------------------------------------
  flns_ram #(
    .WIDTH (COEFF_W),
    .DEPTH (MEMORY_DEPTH)
  ) u_coeff_ram (
    .clk_i   (clk_i),
    .we_i    (coeff_we),
    .waddr_i (in_cidx_ext[IDX_W-1:0]),
    .wdata_i (in_cval),
    .raddr_i (tap_q),
    .rdata_o (coeff_rd)
  );

  flns_mac #(
    .IDX_W (IDX_W)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (mac_clear),
    .tap_i   (tap),
    .hist_i  (cell_w[MEMORY_DEPTH-1]),
    .coeff_i (coeff_rd),
    .busy_o  (mac_busy),
    .mem_o   (mem_term)
  );

  // --------------------------------------------------------------------------
  // Gain products
  // --------------------------------------------------------------------------
  flns_gmul u_gm_in (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (gm_start),
    .gain_i   (input_gain_q),
    .value_i  ({drive_q[31], drive_q}),
    .done_o   (gm_in_done),
    .result_o (gm_in_res)
  );

  flns_gmul u_gm_leak (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (gm_start),
    .gain_i   (leak_gain_q),
    .value_i  (dev_q),
    .done_o   (gm_leak_done),
    .result_o (gm_leak_res)
  );

  assign gm_done = gm_in_done && gm_leak_done;

  // --------------------------------------------------------------------------
  // Membrane update, saturation and firing
  // --------------------------------------------------------------------------
  assign sum_d = SUM_W'(v_q) + SUM_W'(gm_in_res) - SUM_W'(gm_leak_res) - SUM_W'(mem_term);

  assign ovf_hi = !sum_q[SUM_W-1] && (|sum_q[SUM_W-2:31]);
  assign ovf_lo = sum_q[SUM_W-1] && !(&sum_q[SUM_W-2:31]);
  assign v_sat  = ovf_hi ? 32'sh7FFF_FFFF : (ovf_lo ? 32'sh8000_0000 : sum_q[31:0]);

  // a refractory step holds V at the reset potential and never fires
  assign fire   = !refr_q && (v_sat >= thr_q);
  assign v_next = (refr_q || fire) ? reset_q : v_sat;

  // restart the count on a spike, saturate otherwise
  assign since_next = fire ? SINCE_W'(1) :
                      ((since_q == SINCE_MAX) ? SINCE_MAX : since_q + SINCE_W'(1));

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_memb_q, out_spike_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FLNS_ASSERT_IMP(a_sum_after_drain, state_q == ST_SUM, !mac_busy && gm_done)
  `FLNS_ASSERT_IMP(a_spike_at_reset, out_valid_q && out_spike_q, out_memb_q == reset_q)
  `FLNS_ASSERT_NEXT(a_fire_restarts_count, out_load && fire, since_q == SINCE_W'(1))

endmodule

/* rtl/flns_ram.sv */
// ----------------------------------------------------------------------------
// flns_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module flns_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/flns_cell.sv */
// ----------------------------------------------------------------------------
// flns_cell
// One history cell: holds one deviation word, takes its neighbor's on enable.
// ----------------------------------------------------------------------------
module flns_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [31:0] data_i,
  output logic [31:0] data_o
);

  logic [31:0] data_q;
  logic [31:0] data_d;

  assign data_d = en_i ? data_i : data_q;
  assign data_o = data_q;

  // History starts out all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

endmodule

/* rtl/flns_gmul.sv */
// ----------------------------------------------------------------------------
// flns_gmul
// Sequential gain multiplier: unsigned Q16.16 gain times a signed 33-bit
// value, rounded to Q16.16 to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module flns_gmul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [31:0]                     gain_i,
  input  logic signed [32:0]              value_i,
  output logic                            done_o,
  output logic signed [flns_pkg::GM_W-1:0] result_o
);
  import flns_pkg::*;

  flns_gm_phase_e phase_q, phase_d;

  logic [32:0]            mag_q;
  logic                   neg_q;
  logic [16:0]            mul_b;
  logic [48:0]            mul_w;
  logic [48:0]            lo_q;
  logic [48:0]            hi_q;
  logic [65:0]            p_q;
  logic [49:0]            r_q;
  logic signed [GM_W-1:0] res_q;

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      GM_IDLE: if (start_i) phase_d = GM_LO;
      GM_LO:   phase_d = GM_HI;
      GM_HI:   phase_d = GM_SUM;
      GM_SUM:  phase_d = GM_RND;
      GM_RND:  phase_d = GM_SIGN;
      GM_SIGN: phase_d = GM_IDLE;
      default: phase_d = GM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o   = (phase_q == GM_IDLE);
    result_o = res_q;
  end

  // one 32x17 multiplier, low then high half of the magnitude
  assign mul_b = (phase_q == GM_LO) ? mag_q[16:0] : {1'b0, mag_q[32:17]};
  assign mul_w = gain_i * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= GM_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == GM_IDLE && start_i) begin
      mag_q <= value_i[32] ? 33'(-value_i) : 33'(value_i);
      neg_q <= value_i[32];
    end
    if (phase_q == GM_LO) lo_q <= mul_w;
    if (phase_q == GM_HI) hi_q <= mul_w;
    if (phase_q == GM_SUM) p_q <= 66'(lo_q) + {hi_q, 17'b0};
    if (phase_q == GM_RND) r_q <= p_q[65:16] + 50'(p_q[15]);
    if (phase_q == GM_SIGN) begin
      res_q <= neg_q ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    end
  end

endmodule

/* rtl/flns_mac.sv */
// ----------------------------------------------------------------------------
// flns_mac
// Memory-term multiply-accumulate: one coefficient times one history tap per
// cycle, exact Q.32 sum, then rounding to a signed Q16.16 memory term.
// ----------------------------------------------------------------------------
module flns_mac #(
  parameter int unsigned IDX_W = 10,
  localparam int unsigned MEM_W = IDX_W + 35
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clear_i,
  input  flns_pkg::flns_tap_t                  tap_i,
  input  logic signed [31:0]                   hist_i,
  input  logic [flns_pkg::COEFF_W-1:0]         coeff_i,
  output logic                                 busy_o,
  output logic signed [MEM_W-1:0]              mem_o
);
  import flns_pkg::*;

  localparam int unsigned PROD_W = 50;
  localparam int unsigned ACC_W  = PROD_W + IDX_W;
  localparam int unsigned RND_W  = ACC_W - 16;

  // vld_q: tap held, product held, sum updated, magnitude held, rounded held
  logic [4:0]               vld_q;
  logic                     s1_keep_q;
  logic signed [31:0]       s1_hist_q;
  logic signed [PROD_W-1:0] prod_w;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]         mag_q;
  logic                     neg_q;
  logic [RND_W-1:0]         rnd_q;
  logic                     rnd_neg_q;
  logic signed [MEM_W-1:0]  mem_q;

  assign prod_w = $signed({1'b0, coeff_i}) * s1_hist_q;
  assign busy_o = |vld_q;
  assign mem_o  = mem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], tap_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_keep_q <= tap_i.keep;
    s1_hist_q <= hist_i;
    // unused taps contribute nothing, whatever the coefficient slot holds
    prod_q    <= s1_keep_q ? prod_w : '0;
    if (clear_i) begin
      acc_q <= '0;
    end else if (vld_q[1]) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    mag_q     <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    neg_q     <= acc_q[ACC_W-1];
    rnd_q     <= mag_q[ACC_W-1:16] + RND_W'(mag_q[15]);
    rnd_neg_q <= neg_q;
    mem_q     <= rnd_neg_q ? -$signed({1'b0, rnd_q}) : $signed({1'b0, rnd_q});
  end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the fractional-order LIF neuron step block.
// Preloads the memory weights of every tap that the settings put in use,
// runs a short directed sequence under reset gains and potentials, then walks
// a series of register settings (extremes included) with random step and
// weight transactions. A behavioral neuron computes the spike flag and
// membrane potential of each step as it is accepted, and every result is
// compared in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import flns_pkg::*;

  localparam int DEPTH       = 1024;
  // Weights loaded up front; no setting ever sums more taps than this.
  localparam int LOADED      = 64;
  // Active step walks the whole ring once; that bounds every quiet wait.
  localparam int STEP_CYCLES = DEPTH + 10;
  localparam int CFG_PAUSE   = 16;
  localparam int HOLD_CYCLES = 4000;

  // No register lives at this index; writes to it must do nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam longint             L_MAX = 64'sd2147483647;
  localparam longint             L_MIN = -64'sd2147483648;

  typedef struct {
    flns_cmd_e          cmd;
    logic signed [31:0] drive;
    logic [9:0]         slot;
    logic [16:0]        weight;
  } neuron_item_t;

  typedef struct {
    logic               fired;
    logic signed [31:0] membrane;
  } neuron_result_t;

  typedef struct {
    logic [31:0]        leak;
    logic [31:0]        gain;
    logic signed [31:0] rest;
    logic signed [31:0] thresh;
    logic signed [31:0] reset_v;
    logic [15:0]        refr;
    logic [10:0]        taps;
  } neuron_cfg_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports (every input known from time zero)
  // --------------------------------------------------------------------------
  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [63:0]          s_axis_tdata_i  = '0;
  logic [0:0]           s_axis_tuser_i  = CMD_STEP;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [39:0]          m_axis_tdata_o;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = REG_LEAK_GAIN;
  logic [31:0]          cfg_data_i      = '0;

  fractional_lif_neuron_step #(
    .MEMORY_DEPTH(DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Behavioral neuron: register copy and state
  // --------------------------------------------------------------------------
  logic [31:0]        leak_gain  = RST_LEAK_GAIN;
  logic [31:0]        input_gain = RST_INPUT_GAIN;
  logic signed [31:0] rest_pot   = RST_REST;
  logic signed [31:0] threshold  = RST_THRESHOLD;
  logic signed [31:0] reset_pot  = RST_RESET_POT;
  logic [15:0]        refr_steps = RST_REFRACTORY;
  logic [10:0]        hist_taps  = RST_HIST_LEN;

  logic signed [31:0] membrane    = RST_RESET_POT;
  logic [SINCE_W-1:0] since_spike = SINCE_MAX;
  bit signed [31:0]   deviation [DEPTH];
  bit [16:0]          weights [DEPTH];

  neuron_item_t   stimulus [$];
  neuron_result_t membrane_due [$];
  int             mismatches = 0;

  // Traffic shaping shared by the driver, the sink and the pressure process.
  bit gaps_on     = 1'b1;
  bit squeeze_req = 1'b0;
  int hold_left   = 0;

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > L_MAX) return Q_MAX;
    if (x < L_MIN) return Q_MIN;
    return x[31:0];
  endfunction

  // Round a Q.32 magnitude to Q.16, nearest with ties away from zero.
  function automatic longint round_q16(bit [63:0] mag, bit neg);
    longint r;
    r = longint'((mag >> 16) + mag[15]);
    return neg ? -r : r;
  endfunction

  function automatic longint scale_by_gain(logic [31:0] gain, longint value);
    bit [63:0] mag;
    mag = (value < 0) ? 64'(-value) : 64'(value);
    return round_q16(64'(gain) * mag, value < 0);
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      REG_LEAK_GAIN:  leak_gain  = val;
      REG_INPUT_GAIN: input_gain = val;
      REG_REST:       rest_pot   = val;
      REG_THRESHOLD:  threshold  = val;
      REG_RESET_POT:  reset_pot  = val;
      REG_REFRACTORY: refr_steps = val[15:0];
      REG_HIST_LEN:   hist_taps  = val[10:0];
      default: ;
    endcase
  endfunction

  // One time step: shift the deviation line, sum the memory term, integrate,
  // then fire and reset at threshold. Refractory steps only pin V to reset.
  function automatic neuron_result_t advance_membrane(logic signed [31:0] drive);
    neuron_result_t res;
    longint         v;
    longint         vn;
    longint         mem;
    longint         h;
    bit [63:0]      pos_acc;
    bit [63:0]      neg_acc;
    int             taps;
    res.fired = 1'b0;
    if (since_spike > {1'b0, refr_steps}) begin
      v    = longint'(membrane);
      taps = (hist_taps > DEPTH) ? DEPTH : int'(hist_taps);
      for (int i = DEPTH - 1; i > 0; i--) deviation[i] = deviation[i-1];
      deviation[0] = clamp32(v - longint'(reset_pot));
      pos_acc = '0;
      neg_acc = '0;
      for (int i = 0; i < taps; i++) begin
        h = longint'(deviation[i]);
        if (h < 0) neg_acc += 64'(weights[i]) * 64'(-h);
        else       pos_acc += 64'(weights[i]) * 64'(h);
      end
      mem = (pos_acc >= neg_acc) ? round_q16(pos_acc - neg_acc, 1'b0)
                                 : round_q16(neg_acc - pos_acc, 1'b1);
      vn = v + scale_by_gain(input_gain, longint'(drive))
             - scale_by_gain(leak_gain, v - longint'(rest_pot)) - mem;
      membrane = clamp32(vn);
      if (membrane >= threshold) begin
        res.fired   = 1'b1;
        membrane    = reset_pot;
        since_spike = '0;
      end
    end else begin
      membrane = reset_pot;
    end
    if (since_spike < SINCE_MAX) since_spike++;
    res.membrane = membrane;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Item builders; unused fields carry random bits the block must ignore
  // --------------------------------------------------------------------------
  function automatic neuron_item_t step_item(logic signed [31:0] drive);
    neuron_item_t it;
    it.cmd    = CMD_STEP;
    it.drive  = drive;
    it.slot   = 10'($urandom());
    it.weight = 17'($urandom());
    return it;
  endfunction

  function automatic neuron_item_t coeff_item(logic [9:0] slot, logic [16:0] weight);
    neuron_item_t it;
    it.cmd    = CMD_COEFF;
    it.drive  = $urandom();
    it.slot   = slot;
    it.weight = weight;
    return it;
  endfunction

  function automatic logic [16:0] pick_weight();
    if ($urandom_range(0, 7) == 0) return 17'($urandom_range(0, 131071));
    return 17'($urandom_range(0, 511));
  endfunction

  // Mostly moderate currents around zero, with some full-range and rail values.
  function automatic logic signed [31:0] pick_drive(int span);
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      default: return int'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic neuron_cfg_t setting(logic [31:0] leak, logic [31:0] gain,
                                          logic signed [31:0] rest,
                                          logic signed [31:0] thresh,
                                          logic signed [31:0] reset_v,
                                          logic [15:0] refr, logic [10:0] taps);
    neuron_cfg_t c;
    c.leak    = leak;
    c.gain    = gain;
    c.rest    = rest;
    c.thresh  = thresh;
    c.reset_v = reset_v;
    c.refr    = refr;
    c.taps    = taps;
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Stream driver: offer queued transactions, predict each one on acceptance
  // --------------------------------------------------------------------------
  neuron_item_t offered;
  int           send_gap = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        if (offered.cmd == CMD_COEFF) weights[offered.slot] = offered.weight;
        else membrane_due.push_back(advance_membrane(offered.drive));
      end
      // Advance only when the bus is free or its transaction just went through.
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (stimulus.size() != 0) begin
          offered = stimulus.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {5'b0, offered.weight, offered.slot, offered.drive};
          s_axis_tuser_i  <= offered.cmd;
          if (gaps_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stall bursts, dropped entirely during a hold-off
  // --------------------------------------------------------------------------
  int sink_gap = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap--;
      m_axis_tready_i <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 15) == 0) begin
      sink_gap = $urandom_range(0, 7);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Hold off the sink once a result is waiting, long enough that the block
  // finishes the next step against a full output and stalls its input.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (squeeze_req && m_axis_tvalid_o) begin
      squeeze_req = 1'b0;
      hold_left <= HOLD_CYCLES;
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each transaction with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    neuron_result_t     want;
    logic               got_spike;
    logic signed [31:0] got_v;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_spike = m_axis_tdata_o[0];
      got_v     = m_axis_tdata_o[32:1];
      if (membrane_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with no step pending: spike=%0b membrane=%0d",
                   $time, got_spike, got_v);
      end else begin
        want = membrane_due.pop_front();
        if (got_spike !== want.fired || got_v !== want.membrane) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] step result: expected spike=%0b membrane=%0d, ",
                      "got spike=%0b membrane=%0d"},
                     $time, want.fired, want.membrane, got_spike, got_v);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing helpers
  // --------------------------------------------------------------------------
  // Wait until every transaction went in and every result came out, then
  // leave room for a trailing weight write to land.
  task automatic settle();
    do @(negedge clk_i);
    while (stimulus.size() != 0 || s_axis_tvalid_i || membrane_due.size() != 0);
    repeat (CFG_PAUSE) @(negedge clk_i);
  endtask

  // Write all seven registers plus the unmapped index, back to back.
  task automatic program_registers(neuron_cfg_t c);
    logic [CFG_IDX_W-1:0] idx [8];
    logic [31:0]          word [8];
    int                   k;
    idx[0] = REG_LEAK_GAIN;  word[0] = c.leak;
    idx[1] = REG_INPUT_GAIN; word[1] = c.gain;
    idx[2] = REG_REST;       word[2] = c.rest;
    idx[3] = REG_THRESHOLD;  word[3] = c.thresh;
    idx[4] = REG_RESET_POT;  word[4] = c.reset_v;
    idx[5] = REG_REFRACTORY; word[5] = {16'b0, c.refr};
    idx[6] = REG_HIST_LEN;   word[6] = {21'b0, c.taps};
    idx[7] = REG_SPARE;      word[7] = $urandom();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx[0];
    cfg_data_i  <= word[0];
    k = 0;
    while (k < 8) begin
      @(posedge clk_i);
      if (cfg_ready_o) begin
        apply_register(idx[k], word[k]);
        k++;
        if (k < 8) begin
          cfg_index_i <= idx[k];
          cfg_data_i  <= word[k];
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  endtask

  // Mostly steps, with weight rewrites mixed in at random loaded slots.
  task automatic queue_traffic(int n, int span, bit gaps);
    @(negedge clk_i);
    gaps_on = gaps;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0)
        stimulus.push_back(coeff_item(10'($urandom_range(0, LOADED - 1)), pick_weight()));
      else
        stimulus.push_back(step_item(pick_drive(span)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : run
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset gains and potentials, tap count trimmed to the loaded weights.
    program_registers(setting(32'd655, 32'd65536, 32'sd0, 32'sd65536, 32'sd0,
                              16'd2, 11'(LOADED)));

    // Load every weight in use first so no step ever reads an empty slot.
    @(negedge clk_i);
    for (int s = 0; s < LOADED; s++)
      stimulus.push_back(coeff_item(10'(s), 17'($urandom_range(0, 255))));

    // Directed steps: rails, spike and refractory window, extreme deviations,
    // weight rails at both ends of the taps in use.
    stimulus.push_back(step_item(32'sd0));
    stimulus.push_back(step_item(32'sd32768));
    stimulus.push_back(step_item(32'sd32768));
    stimulus.push_back(step_item(Q_MAX));
    stimulus.push_back(step_item(Q_MIN));
    stimulus.push_back(step_item(32'sd0));
    stimulus.push_back(step_item(Q_MIN));
    stimulus.push_back(step_item(Q_MIN));
    stimulus.push_back(step_item(Q_MAX));
    stimulus.push_back(coeff_item(10'd0, 17'h1_FFFF));
    stimulus.push_back(step_item(-32'sd65536));
    stimulus.push_back(step_item(32'sd1));
    stimulus.push_back(coeff_item(10'd0, 17'd0));
    stimulus.push_back(coeff_item(10'(LOADED - 1), 17'h1_FFFF));
    stimulus.push_back(step_item(32'sd0));
    stimulus.push_back(step_item(-32'sd1));
    stimulus.push_back(coeff_item(10'(LOADED - 1), 17'd3));
    stimulus.push_back(step_item(32'sd98304));
    stimulus.push_back(step_item(-32'sd32768));
    settle();

    // Nominal settings; hold off the sink once results start flowing.
    program_registers(setting(32'd655, 32'd65536, 32'sd0, 32'sd65536, 32'sd0,
                              16'd2, 11'(LOADED)));
    @(negedge clk_i);
    squeeze_req = 1'b1;
    queue_traffic(60, 65536, 1'b1);
    settle();

    // No leak, maximum input gain, threshold at the top rail, one tap, no
    // refractory period.
    program_registers(setting(32'd0, 32'hFFFF_FFFF, -32'sd65536, Q_MAX, -32'sd32768,
                              16'd0, 11'd1));
    queue_traffic(40, 256, 1'b1);
    settle();

    // Maximum leak, zero input gain, threshold at the bottom rail so every
    // active step fires, longest refractory period, no taps summed.
    program_registers(setting(32'hFFFF_FFFF, 32'd0, Q_MAX, Q_MIN, Q_MIN,
                              16'hFFFF, 11'd0));
    queue_traffic(40, 65536, 1'b0);
    settle();

    // Reset potential at the top rail while V sits at the bottom one: the
    // stored deviation saturates. Every loaded tap summed.
    program_registers(setting(32'd1311, 32'd49152, Q_MIN, Q_MAX, Q_MAX,
                              16'd0, 11'(LOADED)));
    queue_traffic(40, 262144, 1'b1);
    settle();

    // Random settings in a range that keeps the neuron spiking.
    for (int p = 0; p < 6; p++) begin
      program_registers(setting($urandom_range(0, 6553), $urandom_range(16384, 131072),
                                int'($urandom_range(0, 131072)) - 65536,
                                $urandom_range(16384, 196608),
                                -int'($urandom_range(0, 65536)),
                                16'($urandom_range(0, 4)),
                                11'($urandom_range(1, LOADED))));
      queue_traffic(45, 65536 << $urandom_range(0, 2), 1'($urandom_range(0, 1)));
      settle();
    end

    // Tail with no idling on either side.
    program_registers(setting(32'd3277, 32'd65536, -32'sd65536, 32'sd65536, -32'sd65536,
                              16'd3, 11'(LOADED / 2)));
    queue_traffic(50, 65536, 1'b0);
    settle();

    // Give a stray result time to show up before judging.
    repeat (STEP_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && membrane_due.size() == 0)
      $display("fractional_lif_neuron_step verification clean");
    else
      $display("fractional_lif_neuron_step verification failed");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #80ms;
    $display("fractional_lif_neuron_step verification failed");
    $finish;
  end

endmodule
